>>> design/sts_pkg.sv
// shared types and constants for the stall takeover supervisor
// no dependencies; imported by every design file of the block

package sts_pkg;

   // counter, frequency, limit and register widths
   localparam int TICK_BITS = 32;
   localparam int FREQ_BITS = 20;
   localparam int LIMIT_BITS = 16;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = FREQ_BITS;

   localparam logic [LIMIT_BITS-1:0] SETTLE_MAX = {LIMIT_BITS{1'b1}};

   // event kinds
   typedef enum logic [1:0] {
      KIND_TICK      = 2'd0,
      KIND_HEARTBEAT = 2'd1,
      KIND_KICK      = 2'd2,
      KIND_CLEAR     = 2'd3
   } kind_type;

   // supervisor modes
   typedef enum logic [1:0] {
      MODE_OK       = 2'd0,
      MODE_TAKEOVER = 2'd1,
      MODE_FAULT    = 2'd2
   } mode_type;

   // register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_STALL_LIMIT     = 3'd0,
      CSR_SOFTSTOP_OFFSET = 3'd1,
      CSR_MAX_FREQUENCY   = 3'd2,
      CSR_RAMP_STEP       = 3'd3,
      CSR_SETTLE_LIMIT    = 3'd4
   } csr_index_type;

   // reset values of the registers
   localparam logic [LIMIT_BITS-1:0] STALL_LIMIT_RST     = 16'd100;
   localparam logic [FREQ_BITS-1:0]  SOFTSTOP_OFFSET_RST = 20'd20000;
   localparam logic [FREQ_BITS-1:0]  MAX_FREQUENCY_RST   = 20'd100000;
   localparam logic [FREQ_BITS-1:0]  RAMP_STEP_RST       = 20'd100;
   localparam logic [LIMIT_BITS-1:0] SETTLE_LIMIT_RST    = 16'd50;

   typedef struct packed {
      logic [1:0]           kind;
      logic                 pwm_on;
      logic [FREQ_BITS-1:0] current_freq;
   } req_type;

   typedef struct packed {
      logic [1:0]           safety_mode;
      logic                 freq_cmd_valid;
      logic [FREQ_BITS-1:0] freq_cmd;
      logic                 bridge_off;
      logic                 watchdog_feed;
   } rsp_type;

   typedef struct packed {
      logic [LIMIT_BITS-1:0] stall_limit;
      logic [FREQ_BITS-1:0]  softstop_offset;
      logic [FREQ_BITS-1:0]  max_frequency;
      logic [FREQ_BITS-1:0]  ramp_step;
      logic [LIMIT_BITS-1:0] settle_limit;
   } cfg_type;

   typedef struct packed {
      logic [TICK_BITS-1:0]  tick_count;
      logic [TICK_BITS-1:0]  heartbeat_stamp;
      mode_type              mode;
      logic [FREQ_BITS-1:0]  detune_target;
      logic [LIMIT_BITS-1:0] settle_count;
   } state_type;

endpackage

>>> design/sts_step.sv
// one supervisor step: next state and result for one event
// depends on sts_pkg; purely combinational

module sts_step (
   input  sts_pkg::cfg_type   cfg,
   input  sts_pkg::state_type state_cur,
   input  sts_pkg::req_type   req,
   output sts_pkg::state_type state_nxt,
   output sts_pkg::rsp_type   rsp
);
   import sts_pkg::*;

   logic [TICK_BITS-1:0]  tick_inc;
   logic [TICK_BITS-1:0]  age;
   logic [FREQ_BITS:0]    target_sum;
   logic [FREQ_BITS-1:0]  target_sat;
   logic [FREQ_BITS:0]    ramp_sum;
   logic [FREQ_BITS-1:0]  ramp_sat;
   logic [LIMIT_BITS-1:0] settle_inc;

   // arithmetic used by the tick event branch
   always_comb begin
      tick_inc   = state_cur.tick_count + {{(TICK_BITS-1){1'b0}}, 1'b1};
      age        = tick_inc - state_cur.heartbeat_stamp;
      target_sum = {1'b0, req.current_freq} + {1'b0, cfg.softstop_offset};
      target_sat = (target_sum > {1'b0, cfg.max_frequency}) ?
                   cfg.max_frequency : target_sum[FREQ_BITS-1:0];
      ramp_sum   = {1'b0, req.current_freq} + {1'b0, cfg.ramp_step};
      ramp_sat   = (ramp_sum > {1'b0, state_cur.detune_target}) ?
                   state_cur.detune_target : ramp_sum[FREQ_BITS-1:0];
      settle_inc = (state_cur.settle_count < SETTLE_MAX) ?
                   state_cur.settle_count + {{(LIMIT_BITS-1){1'b0}}, 1'b1} :
                   state_cur.settle_count;
   end

   // event decode and mode transitions
   always_comb begin
      state_nxt          = state_cur;
      rsp                = '0;
      case (kind_type'(req.kind))
         KIND_TICK: begin
            state_nxt.tick_count = tick_inc;
            case (state_cur.mode)
               MODE_OK: begin
                  if (req.pwm_on && (age > {{(TICK_BITS-LIMIT_BITS){1'b0}}, cfg.stall_limit}))
                  begin
                     state_nxt.detune_target = target_sat;
                     state_nxt.settle_count  = '0;
                     state_nxt.mode          = MODE_TAKEOVER;
                  end
               end
               MODE_TAKEOVER: begin
                  rsp.watchdog_feed = 1'b1;
                  if (req.current_freq < state_cur.detune_target) begin
                     rsp.freq_cmd_valid = 1'b1;
                     rsp.freq_cmd       = ramp_sat;
                  end else begin
                     state_nxt.settle_count = settle_inc;
                     if (settle_inc >= cfg.settle_limit) begin
                        rsp.bridge_off = 1'b1;
                        state_nxt.mode = MODE_FAULT;
                     end
                  end
               end
               default: begin
                  // fault: only the counter advances
               end
            endcase
         end
         KIND_HEARTBEAT: begin
            state_nxt.heartbeat_stamp = state_cur.tick_count;
         end
         KIND_KICK: begin
            rsp.watchdog_feed = (state_cur.mode != MODE_TAKEOVER);
         end
         default: begin
            // clear request, honored only in fault with the bridge stopped
            if (state_cur.mode != MODE_OK && state_cur.mode != MODE_TAKEOVER &&
                !req.pwm_on) begin
               state_nxt.settle_count    = '0;
               state_nxt.heartbeat_stamp = state_cur.tick_count;
               state_nxt.mode            = MODE_OK;
            end
         end
      endcase
      rsp.safety_mode = (state_nxt.mode == MODE_OK || state_nxt.mode == MODE_TAKEOVER) ?
                        state_nxt.mode : MODE_FAULT;
   end

endmodule

>>> design/stall_takeover_supervisor_top.sv
// stall takeover supervisor: registers, state and result buffering
// depends on sts_pkg and sts_step
//
// Usage
//   req channel: one event per transfer (tick, heartbeat, watchdog kick or
//   fault clear) with the pwm state and current bridge frequency.
//   rsp channel: exactly one result per event, in order: mode after the
//   event, optional frequency command, bridge-off and watchdog-feed flags.
//   csr port: write enable, index and data; write only while idle.
// Timing
//   an event is processed in the cycle it transfers; its result is
//   registered in the output register, or in the skid register while rsp is
//   stalled. One event per cycle is sustained while rsp is not stalled.
// Stall
//   a skid register catches one result while rsp is stalled, so req_ready
//   drops only once both output and skid registers hold results.
// Reset
//   synchronous, active high: mode ok, counters and target zero, registers
//   to their default values, no result pending.

module stall_takeover_supervisor_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  sts_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output sts_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_write_en,
   input  logic [sts_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [sts_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import sts_pkg::*;

   cfg_type   cfg_ff;
   state_type state_ff;
   state_type state_in;
   rsp_type   step_rsp;
   rsp_type   out_ff;
   rsp_type   skid_ff;
   logic      out_valid_ff;
   logic      skid_valid_ff;
   logic      req_xfer;
   logic      out_free;

   assign req_ready = !skid_valid_ff;
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   sts_step u_step (
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .req       (req_data),
      .state_nxt (state_in),
      .rsp       (step_rsp)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stall_limit     <= STALL_LIMIT_RST;
         cfg_ff.softstop_offset <= SOFTSTOP_OFFSET_RST;
         cfg_ff.max_frequency   <= MAX_FREQUENCY_RST;
         cfg_ff.ramp_step       <= RAMP_STEP_RST;
         cfg_ff.settle_limit    <= SETTLE_LIMIT_RST;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_STALL_LIMIT:     cfg_ff.stall_limit     <= csr_wdata[LIMIT_BITS-1:0];
            CSR_SOFTSTOP_OFFSET: cfg_ff.softstop_offset <= csr_wdata[FREQ_BITS-1:0];
            CSR_MAX_FREQUENCY:   cfg_ff.max_frequency   <= csr_wdata[FREQ_BITS-1:0];
            CSR_RAMP_STEP:       cfg_ff.ramp_step       <= csr_wdata[FREQ_BITS-1:0];
            CSR_SETTLE_LIMIT:    cfg_ff.settle_limit    <= csr_wdata[LIMIT_BITS-1:0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   // supervisor state, updated on each req transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.tick_count      <= '0;
         state_ff.heartbeat_stamp <= '0;
         state_ff.mode            <= MODE_OK;
         state_ff.detune_target   <= '0;
         state_ff.settle_count    <= '0;
      end else if (req_xfer) begin
         state_ff <= state_in;
      end
   end

   // output register plus skid register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (rsp_ready) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end
         end else if (req_xfer) begin
            if (out_free) begin
               out_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // result payloads
   always_ff @(posedge clock) begin
      if (skid_valid_ff && rsp_ready) begin
         out_ff <= skid_ff;
      end else if (req_xfer && out_free) begin
         out_ff <= step_rsp;
      end
      if (req_xfer && !out_free) begin
         skid_ff <= step_rsp;
      end
   end

endmodule

>>> design/sts_checker.sv
// port-level checks for the stall takeover supervisor, bound to the top level
// depends on sts_pkg and stall_takeover_supervisor_top

module sts_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sts_pkg::rsp_type rsp_data
);
   import sts_pkg::*;

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // a frequency command only comes out of takeover
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.freq_cmd_valid |-> rsp_data.safety_mode == MODE_TAKEOVER)
      else $error("frequency command outside takeover");

   // switching off always lands in fault, with no command alongside
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bridge_off |->
         rsp_data.safety_mode == MODE_FAULT && !rsp_data.freq_cmd_valid)
      else $error("bridge off without fault");

   // no frequency without a command
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.freq_cmd_valid |-> rsp_data.freq_cmd == '0)
      else $error("frequency without command");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind stall_takeover_supervisor_top sts_checker u_sts_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
